// ----- design/dtq_pkg.sv -----
// dtq_pkg: shared types and constants for the deadline timer queue
// no dependencies
package dtq_pkg;

  localparam int TS_W     = 64;
  localparam int HANDLE_W = 32;
  localparam int FREQ_W   = 32;
  localparam int PROD_W   = 97;
  localparam int REM_W    = 30;
  localparam int DIG_W    = 16;
  localparam int DIG_N    = 6;

  localparam logic [REM_W-1:0]  SEC_NS       = 30'd1000000000;
  localparam logic [31:0]       SEC_NS_RECIP = 32'd2305843009;  // floor(2^61 / 1e9)
  localparam logic [FREQ_W-1:0] FREQ_RESET   = 32'd62500000;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_EXPIRE = 1'b1;

  typedef struct packed {
    logic [TS_W-1:0]     dl;
    logic [HANDLE_W-1:0] h;
  } dtq_entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } dtq_req_t;

endpackage

// ----- design/deadline_timer_queue.sv -----
// deadline timer queue top: add converts the delay to a deadline and inserts it sorted
// and expire pops the earliest entry; the 32-step multiply and 6-digit divide of the
// conversion run before each insert; a refused add or an empty expire still returns a
// result; in_tready returns in the same cycle that the result registers; rst_n sync
// active low: queue empty, compare value zero, frequency 62500000; depends on dtq_pkg,
// dtq_conv, dtq_store
module deadline_timer_queue #(
  parameter  int QUEUE_DEPTH = 16,
  localparam int CW = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_W = ((99 + CW + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wen,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [159:0]       in_tdata,   // now, after_ns, handle
  input  logic [0:0]         in_tuser,   // op
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata   // accepted, fired, fired_handle, compare_value,
                                         // irq_unmasked, entry_count
);
  import dtq_pkg::*;

  typedef enum logic [2:0] {T_IDLE, T_CONV, T_INS, T_POP, T_WAIT, T_OUT} tstate_t;

  tstate_t             state_r;
  logic [FREQ_W-1:0]   freq_r;
  logic [HANDLE_W-1:0] hin_r;
  logic                acc_r;
  logic                fired_r;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;
  logic                in_xfer;
  logic                conv_start;
  logic                conv_done;
  logic [TS_W-1:0]     deadline;
  dtq_req_t            req;
  logic                st_done;
  logic [HANDLE_W-1:0] pop_handle;
  logic [CW-1:0]       count;
  logic [TS_W-1:0]     compare;

  assign in_tready  = (state_r == T_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign conv_start = in_xfer && in_tuser[0] == OP_ADD && count != CW'(QUEUE_DEPTH);
  assign req.ins    = (state_r == T_CONV) && conv_done;
  assign req.pop    = in_xfer && in_tuser[0] == OP_EXPIRE && count != '0;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  dtq_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (conv_start),
    .now      (in_tdata[63:0]),
    .ns       (in_tdata[127:64]),
    .freq     (freq_r),
    .done     (conv_done),
    .deadline (deadline)
  );

  dtq_store #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .key        (deadline),
    .handle     (hin_r),
    .done       (st_done),
    .pop_handle (pop_handle),
    .count      (count),
    .compare    (compare)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      freq_r      <= FREQ_RESET;
      out_valid_r <= 1'b0;
      acc_r       <= 1'b0;
      fired_r     <= 1'b0;
    end else begin
      if (cfg_wen) begin
        freq_r <= cfg_wdata;
      end
      if (state_r == T_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        out_data_r  <= OUT_W'({count, (count != '0), compare,
                               (fired_r ? pop_handle : {HANDLE_W{1'b0}}),
                               fired_r, acc_r});
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        T_IDLE: begin
          if (in_xfer) begin
            hin_r   <= in_tdata[159:128];
            acc_r   <= 1'b0;
            fired_r <= 1'b0;
            if (conv_start) begin
              state_r <= T_CONV;
            end else if (req.pop) begin
              state_r <= T_POP;
            end else begin
              state_r <= T_OUT;
            end
          end
        end
        T_CONV: begin
          if (conv_done) begin
            state_r <= T_INS;
          end
        end
        T_INS, T_POP: begin
          if (st_done) begin
            acc_r   <= (state_r == T_INS);
            fired_r <= (state_r == T_POP);
            state_r <= T_WAIT;
          end
        end
        T_WAIT: begin
          state_r <= T_OUT;
        end
        T_OUT: begin
          if (!out_valid_r || out_tready) begin
            state_r <= T_IDLE;
          end
        end
        default: begin
          state_r <= T_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/dtq_conv.sv -----
// dtq_conv: delay to deadline conversion, shift-add multiply on one 97-bit adder
// then rounding bias and a 16-bit-digit divide by reciprocal multiply; uses dtq_pkg
module dtq_conv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dtq_pkg::TS_W-1:0]    now,
  input  logic [dtq_pkg::TS_W-1:0]    ns,
  input  logic [dtq_pkg::FREQ_W-1:0]  freq,
  output logic                        done,
  output logic [dtq_pkg::TS_W-1:0]    deadline
);
  import dtq_pkg::*;

  localparam int CUR_W = REM_W + DIG_W;

  typedef enum logic [2:0] {
    C_IDLE, C_MUL, C_BIAS, C_DEST, C_DSUB, C_DFIX, C_DONE
  } cstate_t;

  cstate_t             state_r;
  logic [PROD_W-1:0]   mcand_r;
  logic [FREQ_W-1:0]   mplr_r;
  logic [PROD_W-1:0]   acc_r;
  logic [6:0]          step_r;
  logic [REM_W-1:0]    rem_r;
  logic [TS_W-1:0]     quo_r;
  logic [TS_W-1:0]     now_r;
  logic [63:0]         est_r;
  logic [31:0]         part_r;
  logic [DIG_W-1:0]    qd_r;
  logic [PROD_W-1:0]   addend;
  logic [PROD_W-1:0]   sum;
  logic [CUR_W-1:0]    cur;
  logic [DIG_W-1:0]    qe;
  logic                ge;

  assign addend = (state_r == C_BIAS) ? PROD_W'(SEC_NS - 30'd1) : mcand_r;
  assign sum    = acc_r + addend;
  // partial remainder with the next digit of the dividend appended
  assign cur    = {rem_r, acc_r[PROD_W-2 -: DIG_W]};
  // digit estimate, low by at most one
  assign qe     = est_r[62 -: DIG_W];
  assign ge     = part_r >= 32'(SEC_NS);

  assign done     = (state_r == C_DONE);
  assign deadline = now_r + quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      unique case (state_r)
        C_IDLE: begin
          if (start) begin
            mcand_r <= PROD_W'(ns);
            mplr_r  <= freq;
            acc_r   <= '0;
            step_r  <= '0;
            now_r   <= now;
            state_r <= C_MUL;
          end
        end
        C_MUL: begin
          if (mplr_r[0]) begin
            acc_r <= sum;
          end
          mcand_r <= mcand_r << 1;
          mplr_r  <= mplr_r >> 1;
          step_r  <= step_r + 7'd1;
          if (step_r == 7'(FREQ_W - 1)) begin
            state_r <= C_BIAS;
          end
        end
        C_BIAS: begin
          acc_r   <= sum;
          step_r  <= '0;
          rem_r   <= '0;
          state_r <= C_DEST;
        end
        C_DEST: begin
          est_r   <= 64'(cur[CUR_W-1 -: 32]) * 64'(SEC_NS_RECIP);
          state_r <= C_DSUB;
        end
        C_DSUB: begin
          qd_r    <= qe;
          part_r  <= 32'(cur - CUR_W'(qe) * CUR_W'(SEC_NS));
          state_r <= C_DFIX;
        end
        C_DFIX: begin
          rem_r  <= ge ? REM_W'(part_r - 32'(SEC_NS)) : part_r[REM_W-1:0];
          quo_r  <= {quo_r[TS_W-DIG_W-1:0], qd_r + DIG_W'(ge)};
          acc_r  <= acc_r << DIG_W;
          step_r <= step_r + 7'd1;
          if (step_r == 7'(DIG_N - 1)) begin
            state_r <= C_DONE;
          end else begin
            state_r <= C_DEST;
          end
        end
        C_DONE: begin
          state_r <= C_IDLE;
        end
        default: begin
          state_r <= C_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/dtq_store.sv -----
// dtq_store: sorted deadline store in a single-port-read memory
// insert walks down from the tail, pop shifts entries up; uses dtq_pkg
module dtq_store #(
  parameter int QUEUE_DEPTH = 16,
  parameter int AW = $clog2(QUEUE_DEPTH),
  parameter int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dtq_pkg::dtq_req_t              req,
  input  logic [dtq_pkg::TS_W-1:0]       key,
  input  logic [dtq_pkg::HANDLE_W-1:0]   handle,
  output logic                           done,
  output logic [dtq_pkg::HANDLE_W-1:0]   pop_handle,
  output logic [CW-1:0]                  count,
  output logic [dtq_pkg::TS_W-1:0]       compare
);
  import dtq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ISTEP, S_ICMP, S_PHEAD, S_PSTEP, S_PMOVE, S_FIN
  } sstate_t;

  sstate_t             state_r;
  dtq_entry_t          mem [QUEUE_DEPTH];
  dtq_entry_t          rd_q;
  dtq_entry_t          new_r;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  dtq_entry_t          wr_data;
  logic [CW-1:0]       j_r;
  logic [CW-1:0]       cnt_r;
  logic [TS_W-1:0]     cmp_r;
  logic [HANDLE_W-1:0] ph_r;
  logic                ins_r;

  assign done       = (state_r == S_FIN);
  assign pop_handle = ph_r;
  assign count      = cnt_r;
  assign compare    = cmp_r;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = j_r[AW-1:0];
    wr_data = new_r;
    unique case (state_r)
      S_IDLE: begin
        rd_en = req.pop;
      end
      S_ISTEP: begin
        if (j_r == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(j_r - CW'(1));
        end
      end
      S_ICMP: begin
        wr_en = 1'b1;
        if (rd_q.dl > new_r.dl) begin
          wr_data = rd_q;
        end
      end
      S_PSTEP: begin
        rd_en   = (j_r != cnt_r);
        rd_addr = j_r[AW-1:0];
      end
      S_PMOVE: begin
        wr_en   = 1'b1;
        wr_addr = AW'(j_r - CW'(1));
        wr_data = rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      cmp_r   <= '0;
      ph_r    <= '0;
      ins_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (req.ins) begin
            new_r.dl <= key;
            new_r.h  <= handle;
            j_r      <= cnt_r;
            ins_r    <= 1'b1;
            if (cnt_r == '0 || key < cmp_r) begin
              cmp_r <= key;
            end
            state_r <= S_ISTEP;
          end else if (req.pop) begin
            ins_r   <= 1'b0;
            state_r <= S_PHEAD;
          end
        end
        S_ISTEP: begin
          state_r <= (j_r == '0) ? S_FIN : S_ICMP;
        end
        S_ICMP: begin
          if (rd_q.dl > new_r.dl) begin
            j_r     <= j_r - CW'(1);
            state_r <= S_ISTEP;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_PHEAD: begin
          ph_r    <= rd_q.h;
          j_r     <= CW'(1);
          state_r <= S_PSTEP;
        end
        S_PSTEP: begin
          state_r <= (j_r == cnt_r) ? S_FIN : S_PMOVE;
        end
        S_PMOVE: begin
          if (j_r == CW'(1)) begin
            cmp_r <= rd_q.dl;
          end
          j_r     <= j_r + CW'(1);
          state_r <= S_PSTEP;
        end
        S_FIN: begin
          cnt_r   <= ins_r ? cnt_r + CW'(1) : cnt_r - CW'(1);
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/dtq_checker.sv -----
// dtq_checker: port-level assertions for deadline_timer_queue, bound to the top level
// depends on deadline_timer_queue ports only
module dtq_checker #(
  parameter int QUEUE_DEPTH = 16,
  parameter int CW = $clog2(QUEUE_DEPTH + 1),
  parameter int OUT_W = ((99 + CW + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  a_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[98] == (out_tdata[98+CW:99] != '0))
    else $error("irq flag disagrees with count");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("add and expire flags both set");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[98+CW:99] <= CW'(QUEUE_DEPTH))
    else $error("count beyond depth");

endmodule

bind deadline_timer_queue dtq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dtq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
